// ===== design/assert_macros.svh =====
// Assertion macros shared by the group-size merge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("group-size merge assertion failed");
`define GSM_ASSERT_NEVER(label, clk, rst_n, expr) \
    `GSM_ASSERT(label, clk, rst_n, !(expr))
`else
`define GSM_ASSERT(label, clk, rst_n, prop)
`define GSM_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/gsm_pkg.sv =====
// Shared types and constants for the group-size merge coefficient block.
`timescale 1ns / 1ps
`default_nettype none

package gsm_pkg;

    localparam int IDX_W          = 11;
    localparam int SIZE_W         = 11;
    localparam int FRAC_BITS      = 8;
    localparam int SUM_W          = SIZE_W + 1;
    localparam int PROD_W         = SUM_W + SIZE_W;
    localparam int NUM_W          = PROD_W + FRAC_BITS;
    localparam int COEF_W         = NUM_W - SIZE_W;
    localparam int NUM_POINTS_DEF = 1024;

    localparam logic [SIZE_W-1:0] PAIR_DELTA = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] ONE_DELTA  = SIZE_W'(1);

    typedef struct packed {
        logic [IDX_W-1:0] first_group;
        logic [IDX_W-1:0] second_group;
        logic [IDX_W-1:0] target_index;
    } in_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] from_size;
        logic [SIZE_W-1:0] to_size;
        logic [COEF_W-1:0] coefficient_q8;
        logic              divide_by_zero;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } tbl_rd_req_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] data;
    } tbl_wr_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== design/gsm_table.sv =====
// Group-size table: a two-port memory plus the singleton entry, with a clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gsm_table #(
    parameter int NUM_POINTS = gsm_pkg::NUM_POINTS_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  gsm_pkg::tbl_rd_req_t        rd_req,
    input  gsm_pkg::tbl_wr_req_t        wr_req,
    output logic [gsm_pkg::SIZE_W-1:0]  rd_data,
    output logic                        ready
);
    import gsm_pkg::*;

    localparam int TABLE_DEPTH = (NUM_POINTS < (1 << IDX_W)) ? NUM_POINTS : (1 << IDX_W);
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SIZE_W-1:0] SINGLE_INIT = SIZE_W'(NUM_POINTS % (1 << SIZE_W));
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(TABLE_DEPTH - 1);

    logic [SIZE_W-1:0] mem [TABLE_DEPTH];
    logic [SIZE_W-1:0] mem_q_reg;
    logic [SIZE_W-1:0] alt_q_reg;
    logic              rd_mem_reg;
    logic [SIZE_W-1:0] single_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              rd_in_mem;
    logic              rd_single;
    logic              wr_in_mem;
    logic              wr_single;

    assign rd_in_mem = 32'(rd_req.idx) < TABLE_DEPTH;
    assign rd_single = 32'(rd_req.idx) == NUM_POINTS;
    assign wr_in_mem = 32'(wr_req.idx) < TABLE_DEPTH;
    assign wr_single = 32'(wr_req.idx) == NUM_POINTS;

    // The singleton entry lives in its own register; indices above it read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            single_reg   <= SINGLE_INIT;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (wr_req.en && wr_single) begin
                single_reg <= wr_req.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_req.en && wr_in_mem) begin
            mem[rd_req.en ? wr_req.idx[ADDR_W-1:0] : wr_req.idx[ADDR_W-1:0]] <= wr_req.data;
        end
        if (rd_req.en) begin
            mem_q_reg  <= mem[rd_req.idx[ADDR_W-1:0]];
            rd_mem_reg <= rd_in_mem && !rd_single;
            alt_q_reg  <= rd_single ? single_reg : '0;
        end
    end

    assign rd_data = rd_mem_reg ? mem_q_reg : alt_q_reg;
    assign ready   = !clr_busy_reg;

endmodule

`default_nettype wire

// ===== design/gsm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gsm_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [gsm_pkg::NUM_W-1:0]     num,
    input  wire [gsm_pkg::SIZE_W-1:0]    den,
    output gsm_pkg::div_stat_t           stat,
    output logic [gsm_pkg::COEF_W-1:0]   quotient
);
    import gsm_pkg::*;

    localparam int CNT_W = $clog2(COEF_W);

    logic [SIZE_W-1:0] rem_reg;
    logic [COEF_W-1:0] work_reg;
    logic [SIZE_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W:0]   trial;
    logic              ge;

    // The caller guarantees the quotient fits in COEF_W bits, so the top of the
    // dividend is already below the divisor.
    assign trial = {rem_reg, work_reg[COEF_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num[NUM_W-1:COEF_W];
                work_reg <= num[COEF_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CNT_W'(COEF_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? SIZE_W'(trial - {1'b0, den_reg}) : trial[SIZE_W-1:0];
                work_reg <= {work_reg[COEF_W-2:0], ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

`default_nettype wire

// ===== design/group_size_merge_coefficient_core.sv =====
// Top level of the group-size merge coefficient block: sequencer, table and divider.
`timescale 1ns / 1ps
`default_nettype none

// One merge beat is processed at a time, and s_ready stays low from acceptance until the
// sequencer is idle again. After acceptance it reads both sizes and updates the target
// entry, and when a singleton group takes part also the other entry, each update being a
// read-modify-write. It then multiplies, starts the divider, waits for it and loads the
// output register; when both sizes are zero the divider is skipped. The restoring
// divider retires one of the 20 quotient bits per cycle and raises done with the last bit.
// A merge does up to two reads and two read-modify-write updates through the table's two
// ports. The next beat can be accepted in the cycle after the result is loaded. A finished
// result that still waits on the result channel does not block the next beat. The beat
// after it holds in the output state until the waiting result is taken. After reset the
// block sweeps the size memory once to clear it, covering min(NUM_POINTS, 2048) entries,
// and no beat is accepted during the sweep.

module group_size_merge_coefficient_core #(
    parameter int NUM_POINTS = gsm_pkg::NUM_POINTS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  gsm_pkg::in_item_t    s_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output gsm_pkg::out_item_t   m_item
);
    import gsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TO,
        S_RD_FROM,
        S_UPD1_RD,
        S_UPD1_WR,
        S_UPD2_RD,
        S_UPD2_WR,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        KIND_BOTH,
        KIND_NEITHER,
        KIND_ONE
    } kind_t;

    state_t            state_reg;
    kind_t             kind_reg;
    in_item_t          in_reg;
    logic [IDX_W-1:0]  to_idx_reg;
    logic [IDX_W-1:0]  from_idx_reg;
    logic [SIZE_W-1:0] from_size_reg;
    logic [SIZE_W-1:0] to_size_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SIZE_W-1:0] hi_reg;
    logic              m_valid_reg;
    out_item_t         out_reg;

    logic              a_single;
    logic              b_single;
    logic              a_is_t;
    logic              tbl_ready;
    logic [SIZE_W-1:0] tbl_rd_data;
    tbl_rd_req_t       tbl_rd;
    tbl_wr_req_t       tbl_wr;
    logic              div_start;
    div_stat_t         div_stat;
    logic [COEF_W-1:0] div_quot;
    logic [SIZE_W-1:0] lo_size;
    logic [SIZE_W-1:0] hi_size;
    logic [SUM_W-1:0]  size_sum;
    logic [SIZE_W-1:0] add_delta;
    logic [SIZE_W-1:0] sub_delta;

    assign a_single = 32'(s_item.first_group) == NUM_POINTS;
    assign b_single = 32'(s_item.second_group) == NUM_POINTS;
    assign a_is_t   = s_item.first_group == s_item.target_index;

    assign s_ready = (state_reg == S_IDLE) && tbl_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign lo_size  = (from_size_reg <= to_size_reg) ? from_size_reg : to_size_reg;
    assign hi_size  = (from_size_reg >= to_size_reg) ? from_size_reg : to_size_reg;
    assign size_sum = SUM_W'(from_size_reg) + SUM_W'(to_size_reg);

    // The target gains two, one or the joining size; the other entry loses two or one.
    always_comb begin
        case (kind_reg)
            KIND_BOTH:    add_delta = PAIR_DELTA;
            KIND_ONE:     add_delta = ONE_DELTA;
            KIND_NEITHER: add_delta = from_size_reg;
            default:      add_delta = from_size_reg;
        endcase
        sub_delta = (kind_reg == KIND_BOTH) ? PAIR_DELTA : ONE_DELTA;
    end

    always_comb begin
        tbl_rd    = '0;
        tbl_wr    = '0;
        div_start = 1'b0;
        case (state_reg)
            S_RD_TO: begin
                tbl_rd.en  = 1'b1;
                tbl_rd.idx = to_idx_reg;
            end
            S_RD_FROM: begin
                tbl_rd.en  = 1'b1;
                tbl_rd.idx = from_idx_reg;
            end
            S_UPD1_RD: begin
                tbl_rd.en  = 1'b1;
                tbl_rd.idx = in_reg.target_index;
            end
            S_UPD1_WR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.idx  = in_reg.target_index;
                tbl_wr.data = tbl_rd_data + add_delta;
            end
            S_UPD2_RD: begin
                tbl_rd.en  = 1'b1;
                tbl_rd.idx = from_idx_reg;
            end
            S_UPD2_WR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.idx  = from_idx_reg;
                tbl_wr.data = tbl_rd_data - sub_delta;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In the output state the result register is handled by that state alone.
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg <= s_item;
                        // Both singleton: from_idx is the singleton entry as well.
                        to_idx_reg   <= a_is_t ? s_item.first_group : s_item.second_group;
                        from_idx_reg <= a_is_t ? s_item.second_group : s_item.first_group;
                        if (a_single && b_single) begin
                            kind_reg <= KIND_BOTH;
                        end else if (!a_single && !b_single) begin
                            kind_reg <= KIND_NEITHER;
                        end else begin
                            kind_reg <= KIND_ONE;
                        end
                        state_reg <= S_RD_TO;
                    end
                end
                S_RD_TO: begin
                    state_reg <= S_RD_FROM;
                end
                S_RD_FROM: begin
                    to_size_reg <= (kind_reg == KIND_BOTH) ? ONE_DELTA : tbl_rd_data;
                    state_reg   <= S_UPD1_RD;
                end
                S_UPD1_RD: begin
                    from_size_reg <= (kind_reg == KIND_NEITHER) ? tbl_rd_data : ONE_DELTA;
                    state_reg     <= S_UPD1_WR;
                end
                S_UPD1_WR: begin
                    state_reg <= (kind_reg == KIND_NEITHER) ? S_MUL : S_UPD2_RD;
                end
                S_UPD2_RD: begin
                    state_reg <= S_UPD2_WR;
                end
                S_UPD2_WR: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg <= PROD_W'(size_sum) * PROD_W'(lo_size);
                    hi_reg   <= hi_size;
                    if (hi_size == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The result fields are taken only here, so a waiting beat keeps its payload.
                    if (!m_valid_reg || m_ready) begin
                        out_reg.from_size      <= from_size_reg;
                        out_reg.to_size        <= to_size_reg;
                        out_reg.coefficient_q8 <= (hi_reg == '0) ? '0 : div_quot;
                        out_reg.divide_by_zero <= (hi_reg == '0);
                        m_valid_reg            <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    gsm_table #(
        .NUM_POINTS (NUM_POINTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (tbl_rd),
        .wr_req  (tbl_wr),
        .rd_data (tbl_rd_data),
        .ready   (tbl_ready)
    );

    gsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      ({prod_reg, FRAC_BITS'(0)}),
        .den      (hi_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

`include "assert_macros.svh"

    `GSM_ASSERT(a_one_beat_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `GSM_ASSERT_NEVER(a_div_start_while_busy, aclk, aresetn, div_start && div_stat.busy)
    `GSM_ASSERT_NEVER(a_write_during_clear, aclk, aresetn, tbl_wr.en && !tbl_ready)
    `GSM_ASSERT(a_result_from_out_state, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == S_OUT))

endmodule

`default_nettype wire
